>>> rtl/core/tsfs_pkg.sv
// Types and constants shared by the tiled surface fence sizer.
// No dependencies.
`default_nettype none

package tsfs_pkg;

    typedef enum logic [1:0] {
        TILE_LINEAR = 2'd0,
        TILE_X      = 2'd1,
        TILE_Y      = 2'd2
    } tiling_t;

    typedef enum logic {
        CFG_GPU_GEN      = 1'b0,
        CFG_LINEAR_ALIGN = 1'b1
    } cfg_index_t;

    localparam int ROW_W    = 16;
    localparam int HIN_W    = 14;
    localparam int MODE_W   = 2;
    localparam int GEN_W    = 8;
    localparam int ALIGN_W  = 13;
    localparam int OPITCH_W = 16;
    localparam int OSIZE_W  = 29;

    // internal widths: aligned pitch, aligned height, raw size
    localparam int PITCH_W  = 17;
    localparam int HEIGHT_W = 15;
    localparam int SIZE_W   = 32;

    localparam logic [GEN_W-1:0]   GEN_RESET       = 8'd64;
    localparam logic [ALIGN_W-1:0] LIN_ALIGN_RESET = 13'd64;

    localparam logic [GEN_W-1:0] GEN4_MASK    = 8'h80;
    localparam logic [GEN_W-1:0] GEN3UP_MASK  = 8'hC0;
    localparam logic [GEN_W-1:0] Y128_MASK    = 8'hCF;
    localparam logic [GEN_W-1:0] Y128_THRESH  = 8'h40;

    localparam logic [PITCH_W-1:0] TILE_ALIGN_M1 = 17'd511;
    localparam logic [PITCH_W-1:0] TILE_W_STD    = 17'd512;
    localparam logic [PITCH_W-1:0] TILE_W_Y128   = 17'd128;

    localparam logic [HEIGHT_W-1:0] HX_ALIGN_M1  = 15'd7;
    localparam logic [HEIGHT_W-1:0] HY_ALIGN_M1  = 15'd31;
    localparam logic [HEIGHT_W-1:0] HL_ALIGN_M1  = 15'd1;

    localparam logic [SIZE_W-1:0] FENCE_ALIGN_M1 = 32'd4095;
    localparam logic [SIZE_W-1:0] MIN_SIZE_GEN3  = 32'h0010_0000;
    localparam logic [SIZE_W-1:0] MIN_SIZE_GEN2  = 32'h0008_0000;

    localparam logic [OPITCH_W-1:0] PITCH_MAX = 16'hFFFF;
    localparam logic [OSIZE_W-1:0]  SIZE_MAX  = 29'h1FFF_FFFF;

    typedef struct packed {
        logic tiled;
        logic gen4;
        logic gen3_up;
        logic tile128;
    } flags_t;

endpackage

`default_nettype wire

>>> rtl/core/tsfs_if.sv
// Valid/ready channels of the fence sizer: surface request in, fence result out.
// Depends on tsfs_pkg for field widths.
`default_nettype none

interface tsfs_in_if;
    logic                          valid;
    logic                          ready;
    logic [tsfs_pkg::ROW_W-1:0]    row_bytes;
    logic [tsfs_pkg::HIN_W-1:0]    surface_height;
    logic [tsfs_pkg::MODE_W-1:0]   tile_mode;

    modport source (output valid, output row_bytes, output surface_height,
                    output tile_mode, input ready);
    modport sink   (input valid, input row_bytes, input surface_height,
                    input tile_mode, output ready);
endinterface

interface tsfs_out_if;
    logic                          valid;
    logic                          ready;
    logic [tsfs_pkg::OPITCH_W-1:0] fenced_pitch;
    logic [tsfs_pkg::OSIZE_W-1:0]  fenced_size;

    modport source (output valid, output fenced_pitch, output fenced_size, input ready);
    modport sink   (input valid, input fenced_pitch, input fenced_size, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tsfs_pow2_ceil.sv
// Power-of-two round-up with a lower bound, by bit smearing of value-1.
// No dependencies.
`default_nettype none

module tsfs_pow2_ceil #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] value,
    input  logic [WIDTH-1:0] floor_val,
    output logic [WIDTH-1:0] result
);

    localparam int STEPS = $clog2(WIDTH);

    logic [WIDTH-1:0] smear;

    always_comb
    begin
        smear = value - {{(WIDTH-1){1'b0}}, 1'b1};
        for (int i = 0; i < STEPS; i++)
        begin
            smear = smear | (smear >> (1 << i));
        end
        // floor_val is itself a power of two, so it covers zero too
        if (value <= floor_val)
            result = floor_val;
        else
            result = smear + {{(WIDTH-1){1'b0}}, 1'b1};
    end

endmodule

`default_nettype wire

>>> rtl/core/tiled_surface_fence_sizer.sv
// Fence sizer top level: four-stage pipeline from surface request to fence result.
// Depends on tsfs_pkg, tsfs_if and tsfs_pow2_ceil.
//
// Takes one request per clock unless a stalled result backs up the pipeline, and
// returns one result per request, in order. The stages are: pitch and height
// alignment, power-of-two pitch rounding, the pitch-by-height multiply, and size
// rounding with saturation. Each stage holds its own valid bit and takes new data
// whenever it is empty or its successor moves, so a stalled result holds only the
// stages behind it that are full. Configuration is sampled as each request enters
// and must be written while the pipeline is empty.
`default_nettype none

module tiled_surface_fence_sizer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [tsfs_pkg::ALIGN_W-1:0] cfg_data,
    tsfs_in_if.sink                      req,
    tsfs_out_if.source                   res
);

    // configuration
    logic [tsfs_pkg::GEN_W-1:0]   gen_reg;
    logic [tsfs_pkg::ALIGN_W-1:0] lin_align_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg       <= tsfs_pkg::GEN_RESET;
            lin_align_reg <= tsfs_pkg::LIN_ALIGN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsfs_pkg::CFG_GPU_GEN:      gen_reg <= cfg_data[tsfs_pkg::GEN_W-1:0];
                tsfs_pkg::CFG_LINEAR_ALIGN: lin_align_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !v4_reg || res.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign req.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= req.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage 1: align pitch and height
    logic [tsfs_pkg::PITCH_W-1:0]  pitch1_reg, pitch1_next;
    logic [tsfs_pkg::HEIGHT_W-1:0] height1_reg, height1_next;
    tsfs_pkg::flags_t              flags1_reg, flags1_next;
    logic [tsfs_pkg::PITCH_W-1:0]  row_ext;
    logic [tsfs_pkg::HEIGHT_W-1:0] h_ext;
    logic [tsfs_pkg::PITCH_W-1:0]  lin_m1;
    logic                          y128;

    always_comb
    begin
        row_ext = {1'b0, req.row_bytes};
        h_ext   = {1'b0, req.surface_height};
        // zero alignment behaves as one
        lin_m1  = (lin_align_reg == '0) ? '0 :
                  {4'b0, lin_align_reg - {{(tsfs_pkg::ALIGN_W-1){1'b0}}, 1'b1}};
        y128    = (gen_reg & tsfs_pkg::Y128_MASK) > tsfs_pkg::Y128_THRESH;

        flags1_next.gen4    = (gen_reg & tsfs_pkg::GEN4_MASK) != '0;
        flags1_next.gen3_up = (gen_reg & tsfs_pkg::GEN3UP_MASK) != '0;

        case (req.tile_mode)
            tsfs_pkg::TILE_X:
            begin
                pitch1_next = (row_ext + tsfs_pkg::TILE_ALIGN_M1) & ~tsfs_pkg::TILE_ALIGN_M1;
                height1_next = (h_ext + tsfs_pkg::HX_ALIGN_M1) & ~tsfs_pkg::HX_ALIGN_M1;
                flags1_next.tiled   = 1'b1;
                flags1_next.tile128 = 1'b0;
            end
            tsfs_pkg::TILE_Y:
            begin
                pitch1_next = (row_ext + tsfs_pkg::TILE_ALIGN_M1) & ~tsfs_pkg::TILE_ALIGN_M1;
                height1_next = (h_ext + tsfs_pkg::HY_ALIGN_M1) & ~tsfs_pkg::HY_ALIGN_M1;
                flags1_next.tiled   = 1'b1;
                flags1_next.tile128 = y128;
            end
            default:
            begin
                // linear, and the unused mode code
                pitch1_next  = (row_ext + lin_m1) & ~lin_m1;
                height1_next = (h_ext + tsfs_pkg::HL_ALIGN_M1) & ~tsfs_pkg::HL_ALIGN_M1;
                flags1_next.tiled   = 1'b0;
                flags1_next.tile128 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            pitch1_reg  <= pitch1_next;
            height1_reg <= height1_next;
            flags1_reg  <= flags1_next;
        end
    end

    // stage 2: pre-gen4 tiled pitch goes to a power of two
    logic [tsfs_pkg::PITCH_W-1:0]  pitch2_reg, pitch2_next;
    logic [tsfs_pkg::HEIGHT_W-1:0] height2_reg;
    tsfs_pkg::flags_t              flags2_reg;
    logic [tsfs_pkg::PITCH_W-1:0]  tile_w;
    logic [tsfs_pkg::PITCH_W-1:0]  pitch_pow2;

    assign tile_w = flags1_reg.tile128 ? tsfs_pkg::TILE_W_Y128 : tsfs_pkg::TILE_W_STD;

    tsfs_pow2_ceil #(
        .WIDTH (tsfs_pkg::PITCH_W)
    ) u_pitch_pow2 (
        .value     (pitch1_reg),
        .floor_val (tile_w),
        .result    (pitch_pow2)
    );

    // gen4 tile alignment is a no-op after the 512 alignment
    assign pitch2_next = (flags1_reg.tiled && !flags1_reg.gen4) ? pitch_pow2 : pitch1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            pitch2_reg  <= pitch2_next;
            height2_reg <= height1_reg;
            flags2_reg  <= flags1_reg;
        end
    end

    // stage 3: raw size and pitch saturation
    logic [tsfs_pkg::SIZE_W-1:0]   size3_reg, size3_next;
    logic [tsfs_pkg::OPITCH_W-1:0] pitch3_reg, pitch3_next;
    tsfs_pkg::flags_t              flags3_reg;

    assign size3_next  = {15'b0, pitch2_reg} * {17'b0, height2_reg};
    assign pitch3_next = pitch2_reg[tsfs_pkg::PITCH_W-1] ? tsfs_pkg::PITCH_MAX
                                                        : pitch2_reg[tsfs_pkg::OPITCH_W-1:0];

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            size3_reg  <= size3_next;
            pitch3_reg <= pitch3_next;
            flags3_reg <= flags2_reg;
        end
    end

    // stage 4: size fence rounding and saturation
    logic [tsfs_pkg::OPITCH_W-1:0] pitch4_reg;
    logic [tsfs_pkg::OSIZE_W-1:0]  size4_reg, size4_next;
    logic [tsfs_pkg::SIZE_W-1:0]   min_size;
    logic [tsfs_pkg::SIZE_W-1:0]   size_pow2;
    logic [tsfs_pkg::SIZE_W-1:0]   size_rounded;

    assign min_size = flags3_reg.gen3_up ? tsfs_pkg::MIN_SIZE_GEN3 : tsfs_pkg::MIN_SIZE_GEN2;

    tsfs_pow2_ceil #(
        .WIDTH (tsfs_pkg::SIZE_W)
    ) u_size_pow2 (
        .value     (size3_reg),
        .floor_val (min_size),
        .result    (size_pow2)
    );

    always_comb
    begin
        if (!flags3_reg.tiled)
            size_rounded = size3_reg;
        else if (flags3_reg.gen4)
            size_rounded = (size3_reg + tsfs_pkg::FENCE_ALIGN_M1) & ~tsfs_pkg::FENCE_ALIGN_M1;
        else
            size_rounded = size_pow2;

        if (size_rounded > {3'b0, tsfs_pkg::SIZE_MAX})
            size4_next = tsfs_pkg::SIZE_MAX;
        else
            size4_next = size_rounded[tsfs_pkg::OSIZE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            size4_reg  <= size4_next;
            pitch4_reg <= pitch3_reg;
        end
    end

    assign res.valid        = v4_reg;
    assign res.fenced_pitch = pitch4_reg;
    assign res.fenced_size  = size4_reg;

    // checks
    a_pow2_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && flags2_reg.tiled && !flags2_reg.gen4 |-> $onehot(pitch2_reg))
        else $error("pre-gen4 tiled pitch is not a power of two");

    a_gen4_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && flags2_reg.tiled && flags2_reg.gen4 |-> pitch2_reg[8:0] == '0)
        else $error("gen4 tiled pitch not 512 aligned");

    a_tiled_height: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && flags1_reg.tiled |-> height1_reg[2:0] == '0)
        else $error("tiled height not aligned to 8");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !rdy4 |=> v3_reg && $stable(size3_reg))
        else $error("stalled stage 3 request lost or changed");

endmodule

`default_nettype wire
